// ===== rtl/cosine_similarity_unit_assert.svh =====
// Assertion macros for the cosine similarity unit.
`ifndef COSINE_SIMILARITY_UNIT_ASSERT_SVH
`define COSINE_SIMILARITY_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define CSU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define CSU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CSU_ASSERT(label, clk, rst, prop, msg)

`define CSU_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/csu_pkg.sv =====
package csu_pkg;

   localparam int ELEM_WIDTH_DEF = 16;
   localparam int ACC_W          = 48;
   localparam int SIM_W          = 16;
   localparam int ROOT_W         = 32;
   localparam int RAD_W          = 64;
   localparam int NORM_SHIFT     = 16;

   localparam logic [RAD_W-1:0] SQRT_BIT0 = RAD_W'(1) << (RAD_W - 2);

   localparam logic [ROOT_W-1:0] POS_LIMIT = ROOT_W'((1 << (SIM_W - 1)) - 1);
   localparam logic [ROOT_W-1:0] NEG_LIMIT = ROOT_W'(1 << (SIM_W - 1));

endpackage

// ===== rtl/csu_req_if.sv =====
interface csu_req_if #(
   parameter int ELEM_W = csu_pkg::ELEM_WIDTH_DEF
);
   logic                     valid;
   logic                     ready;
   logic signed [ELEM_W-1:0] elem_a;
   logic signed [ELEM_W-1:0] elem_b;
   logic                     last;

   modport source (output valid, output elem_a, output elem_b, output last, input ready);
   modport sink   (input valid, input elem_a, input elem_b, input last, output ready);
endinterface

// ===== rtl/csu_rsp_if.sv =====
interface csu_rsp_if;
   import csu_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [SIM_W-1:0] similarity;
   logic                    zero_norm;

   modport source (output valid, output similarity, output zero_norm, input ready);
   modport sink   (input valid, input similarity, input zero_norm, output ready);
endinterface

// ===== rtl/cosine_similarity_unit.sv =====
// Cosine similarity of two vectors streamed one element pair per transaction on req_chan
// (signed Q1.15 elements, last marks the final pair). The block has one multiplier, which
// forms a*b, a*a and b*b in turn for each pair and feeds 48-bit saturating accumulators;
// req_chan.ready is high only between pairs. After the last pair the same multiplier and
// one shared 65-bit subtractor finish the result: a zero-norm check, two 32-step square
// roots, the root product, a range compare, a 32-step long division and the rounding
// step. A saturating magnitude skips the division, and a zero norm skips all after the check.
// The result sits in an output register on rsp_chan; the next vector may stream in while it
// waits, and the block stalls at the end of that next vector until the previous result has
// been taken.
`include "cosine_similarity_unit_assert.svh"

module cosine_similarity_unit #(
   parameter int ELEM_WIDTH = csu_pkg::ELEM_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   csu_req_if.sink    req_chan,
   csu_rsp_if.source  rsp_chan
);
   import csu_pkg::*;

   localparam int MUL_W = ((ELEM_WIDTH > ROOT_W) ? ELEM_WIDTH : ROOT_W) + 1;
   localparam int PRD_W = 2 * ELEM_WIDTH;
   localparam int SUM_W = ((PRD_W > ACC_W) ? PRD_W : ACC_W) + 1;
   localparam int SUB_W = RAD_W + 1;
   localparam int CNT_W = $clog2(ROOT_W);

   localparam logic signed [SUM_W-1:0] SUM_HI = (SUM_W'(1) <<< (ACC_W - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] SUM_LO = -(SUM_W'(1) <<< (ACC_W - 1));

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_AA,
      ST_MUL_BB,
      ST_CHECK,
      ST_SQRT_A,
      ST_SQRT_B,
      ST_MUL_D,
      ST_CMP,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;

   logic signed [ELEM_WIDTH-1:0] a_ff, a_in, b_ff, b_in;
   logic                         last_ff, last_in;
   logic signed [ACC_W-1:0]      dot_acc_ff, dot_acc_in;
   logic signed [ACC_W-1:0]      norm_a_acc_ff, norm_a_acc_in;
   logic signed [ACC_W-1:0]      norm_b_acc_ff, norm_b_acc_in;
   logic [RAD_W-1:0]             work_ff, work_in;
   logic [RAD_W-1:0]             root_ff, root_in;
   logic [RAD_W-1:0]             bit_ff, bit_in;
   logic [RAD_W-1:0]             d_ff, d_in;
   logic [ROOT_W-1:0]            ra_ff, ra_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [SIM_W-1:0]      sim_ff, sim_in;
   logic                         zn_ff, zn_in;

   logic signed [MUL_W-1:0]   mul_x, mul_y;
   logic signed [2*MUL_W-1:0] mul_p;
   logic signed [PRD_W-1:0]   elem_prod;

   logic [SUB_W-1:0] sub_a, sub_b;
   logic [SUB_W:0]   sub_diff;
   logic             sub_ge;

   logic             out_free, res_load, last_step, zero_norm, neg;
   logic [ACC_W-1:0] dot_mag;
   logic [RAD_W-1:0] sq_root_nx, sq_work_nx;
   logic [ROOT_W:0]  q_sum;
   logic [ROOT_W-1:0] q_val, q_lim, q_sat;
   logic [SIM_W-1:0] q_mag;

   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0] acc,
      input logic signed [PRD_W-1:0] prod
   );
      logic signed [SUM_W-1:0] s;
      s = SUM_W'(acc) + SUM_W'(prod);
      if (s > SUM_HI) begin
         return SUM_HI[ACC_W-1:0];
      end else if (s < SUM_LO) begin
         return SUM_LO[ACC_W-1:0];
      end
      return s[ACC_W-1:0];
   endfunction

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            mul_x = MUL_W'(req_chan.elem_a);
            mul_y = MUL_W'(req_chan.elem_b);
         end
         ST_MUL_AA: begin
            mul_x = MUL_W'(a_ff);
            mul_y = MUL_W'(a_ff);
         end
         ST_MUL_BB: begin
            mul_x = MUL_W'(b_ff);
            mul_y = MUL_W'(b_ff);
         end
         ST_MUL_D: begin
            mul_x = $signed({{(MUL_W - ROOT_W){1'b0}}, ra_ff});
            mul_y = $signed({{(MUL_W - ROOT_W){1'b0}}, root_ff[ROOT_W-1:0]});
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   assign mul_p     = mul_x * mul_y;
   assign elem_prod = mul_p[PRD_W-1:0];

   assign neg     = dot_acc_ff[ACC_W-1];
   assign dot_mag = neg ? (~dot_acc_ff + ACC_W'(1)) : dot_acc_ff;

   always_comb begin
      case (state_ff)
         ST_SQRT_A, ST_SQRT_B: begin
            sub_a = {1'b0, work_ff};
            sub_b = {1'b0, root_ff | bit_ff};
         end
         ST_DIV: begin
            sub_a = {work_ff, 1'b0};
            sub_b = {1'b0, d_ff};
         end
         ST_CMP: begin
            sub_a = {1'b0, dot_mag, {NORM_SHIFT{1'b0}}};
            sub_b = {1'b0, d_ff};
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
   end

   assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge   = ~sub_diff[SUB_W];

   assign sq_work_nx = sub_ge ? sub_diff[RAD_W-1:0] : work_ff;
   assign sq_root_nx = sub_ge ? ((root_ff >> 1) | bit_ff) : (root_ff >> 1);

   assign out_free  = ~rsp_valid_ff | rsp_chan.ready;
   assign last_step = (cnt_ff == CNT_W'(ROOT_W - 1));
   assign zero_norm = (norm_a_acc_ff[ACC_W-1] || norm_a_acc_ff == '0 ||
                       norm_b_acc_ff[ACC_W-1] || norm_b_acc_ff == '0);

   assign q_sum = {1'b0, root_ff[ROOT_W-1:0]} + (ROOT_W + 1)'(1);
   assign q_val = q_sum[ROOT_W:1];
   assign q_lim = neg ? NEG_LIMIT : POS_LIMIT;
   assign q_sat = (q_val > q_lim) ? q_lim : q_val;
   assign q_mag = q_sat[SIM_W-1:0];

   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      last_in       = last_ff;
      dot_acc_in    = dot_acc_ff;
      norm_a_acc_in = norm_a_acc_ff;
      norm_b_acc_in = norm_b_acc_ff;
      work_in       = work_ff;
      root_in       = root_ff;
      bit_in        = bit_ff;
      d_in          = d_ff;
      ra_in         = ra_ff;
      cnt_in        = cnt_ff;
      sim_in        = sim_ff;
      zn_in         = zn_ff;
      res_load      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               a_in       = req_chan.elem_a;
               b_in       = req_chan.elem_b;
               last_in    = req_chan.last;
               dot_acc_in = sat_add(dot_acc_ff, elem_prod);
               state_in   = ST_MUL_AA;
            end
         end
         ST_MUL_AA: begin
            norm_a_acc_in = sat_add(norm_a_acc_ff, elem_prod);
            state_in      = ST_MUL_BB;
         end
         ST_MUL_BB: begin
            norm_b_acc_in = sat_add(norm_b_acc_ff, elem_prod);
            state_in      = last_ff ? ST_CHECK : ST_IDLE;
         end
         ST_CHECK: begin
            if (zero_norm) begin
               if (out_free) begin
                  res_load = 1'b1;
                  sim_in   = '0;
                  zn_in    = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               work_in  = {norm_a_acc_ff, {NORM_SHIFT{1'b0}}};
               root_in  = '0;
               bit_in   = SQRT_BIT0;
               cnt_in   = '0;
               state_in = ST_SQRT_A;
            end
         end
         ST_SQRT_A, ST_SQRT_B: begin
            work_in = sq_work_nx;
            root_in = sq_root_nx;
            bit_in  = bit_ff >> 2;
            cnt_in  = cnt_ff + CNT_W'(1);
            if (last_step) begin
               if (state_ff == ST_SQRT_A) begin
                  ra_in    = sq_root_nx[ROOT_W-1:0];
                  work_in  = {norm_b_acc_ff, {NORM_SHIFT{1'b0}}};
                  root_in  = '0;
                  bit_in   = SQRT_BIT0;
                  cnt_in   = '0;
                  state_in = ST_SQRT_B;
               end else begin
                  state_in = ST_MUL_D;
               end
            end
         end
         ST_MUL_D: begin
            d_in     = mul_p[RAD_W-1:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (sub_ge) begin
               root_in  = '1;
               state_in = ST_FIN;
            end else begin
               work_in  = RAD_W'(dot_mag);
               root_in  = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            work_in = sub_ge ? sub_diff[RAD_W-1:0] : {work_ff[RAD_W-2:0], 1'b0};
            root_in = {root_ff[RAD_W-2:0], sub_ge};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (last_step) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               res_load = 1'b1;
               sim_in   = neg ? $signed(~q_mag + SIM_W'(1)) : $signed(q_mag);
               zn_in    = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (res_load) begin
         dot_acc_in    = '0;
         norm_a_acc_in = '0;
         norm_b_acc_in = '0;
      end

      rsp_valid_in = res_load | (rsp_valid_ff & ~rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         dot_acc_ff    <= '0;
         norm_a_acc_ff <= '0;
         norm_b_acc_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         dot_acc_ff    <= dot_acc_in;
         norm_a_acc_ff <= norm_a_acc_in;
         norm_b_acc_ff <= norm_b_acc_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      last_ff <= last_in;
      work_ff <= work_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      d_ff    <= d_in;
      ra_ff   <= ra_in;
      cnt_ff  <= cnt_in;
      sim_ff  <= sim_in;
      zn_ff   <= zn_in;
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.similarity = sim_ff;
   assign rsp_chan.zero_norm  = zn_ff;

   `CSU_ASSERT(a_zero_norm_sim, clock, reset, (rsp_valid_ff && zn_ff) |-> (sim_ff == '0), "zero norm result with nonzero similarity")
   `CSU_ASSERT(a_acc_clear, clock, reset, res_load |=> (dot_acc_ff == '0 && norm_a_acc_ff == '0 && norm_b_acc_ff == '0), "accumulators not cleared after result")
   `CSU_ASSERT(a_norm_nonneg, clock, reset, !norm_a_acc_ff[ACC_W-1] && !norm_b_acc_ff[ACC_W-1], "norm accumulator went negative")
   `CSU_ASSERT(a_sqrt_bit, clock, reset, (state_ff == ST_SQRT_A || state_ff == ST_SQRT_B) |-> $onehot(bit_ff), "root trial bit not one-hot")
   `CSU_ASSERT(a_div_rem, clock, reset, (state_ff == ST_DIV) |-> (work_ff < d_ff), "division remainder not below divisor")

endmodule
